/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [3:0] RESET_FG     = 4'hF;
  localparam logic [3:0] RESET_BG     = 4'h0;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_FINISH,
    ST_READ,
    ST_HOLD
  } state_t;

endpackage

/* rtl/core/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode character grid: put, clear and read of 16-bit cells.
// ----------------------------------------------------------------------------
// Input words (op, char_code, cell_index) arrive on in_valid/in_stall, one
// result word (cursor_pos, read_char, read_attr) leaves on out_valid/out_stall
// per input word. Colors are set through cfg_we/cfg_index/cfg_data.
// Operations (the cell RAM has one write and one read port):
//   put without scroll, op 3, out-of-range read: one word per cycle
//     while the output is not stalled. read: RAM read register, then
//     output register. newline or wrap on the last row: scroll copies
//     ROWS*COLS-COLS cells at one per cycle, then blanks the bottom row.
//   clear: ROWS*COLS cells blanked, one cell written per cycle.
// Input is stalled while a scroll, clear or read is in progress.
// Reset: cursor homes, colors return to white on black, and a clearing pass
// blanks all ROWS*COLS cells; in_stall stays high meanwhile, while
// configuration writes are still taken.
// Receiver stall: the result sits in the output register; one more word can
// be accepted and its result is held, after which in_stall rises until the
// output drains.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam int NCELLS    = ROWS * COLS;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int POS_W     = $clog2(NCELLS + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS + 1);
  localparam int LAST_BASE = (ROWS - 1) * COLS;
  localparam int COPY_LAST = NCELLS - COLS - 1;

  tcw_pkg::state_t    state, state_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [POS_W-1:0]   lin, lin_next;
  logic [POS_W-1:0]   cnt, cnt_next;
  logic               cp_valid, cp_valid_next;
  logic [ADDR_W-1:0]  cp_addr, cp_addr_next;
  logic               walk_item, walk_item_next;
  logic [7:0]         walk_attr, walk_attr_next;
  logic               pend_put, pend_put_next;
  logic [7:0]         pend_char, pend_char_next;
  logic [3:0]         fg, bg;
  logic               out_valid_next;
  tcw_pkg::out_word_t out_word_next, hold_word, hold_word_next, done_word;
  logic               done;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [15:0]        wdata, rdata;

  logic               in_acc, out_free, is_nl, at_last_row, col_full, idx_ok;
  logic               go_scroll, go_read;
  logic [7:0]         cur_attr;

  function automatic logic [10:0] to_pos11(input logic [POS_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[10:0];
  endfunction

  assign in_stall    = (state != tcw_pkg::ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign cur_attr    = {bg, fg};
  assign is_nl       = (in_word.char_code == tcw_pkg::NEWLINE_CHAR);
  assign at_last_row = (row == ROW_W'(ROWS - 1));
  assign col_full    = (col >= COL_W'(COLS));
  assign idx_ok      = (32'(in_word.cell_index) < NCELLS);
  assign go_scroll   = (in_word.op == tcw_pkg::OP_PUT) && at_last_row && (is_nl || col_full);
  assign go_read     = (in_word.op == tcw_pkg::OP_READ) && idx_ok;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(NCELLS)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (go_scroll) begin
            state_next = tcw_pkg::ST_SCROLL;
          end else if (in_word.op == tcw_pkg::OP_CLEAR) begin
            state_next = tcw_pkg::ST_BLANK;
          end else if (go_read) begin
            state_next = tcw_pkg::ST_READ;
          end else if (!out_free) begin
            state_next = tcw_pkg::ST_HOLD;
          end
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt == POS_W'(COPY_LAST)) begin
          state_next = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_BLANK: begin
        if (!cp_valid && cnt == POS_W'(NCELLS - 1)) begin
          state_next = walk_item ? tcw_pkg::ST_FINISH : tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_FINISH, tcw_pkg::ST_READ: begin
        state_next = out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_HOLD;
      end
      tcw_pkg::ST_HOLD: begin
        if (!out_stall) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    row_next       = row;
    col_next       = col;
    lin_next       = lin;
    cnt_next       = cnt;
    cp_valid_next  = 1'b0;
    cp_addr_next   = cp_addr;
    walk_item_next = walk_item;
    walk_attr_next = walk_attr;
    pend_put_next  = pend_put;
    pend_char_next = pend_char;
    re             = 1'b0;
    raddr          = '0;
    we             = cp_valid;
    waddr          = cp_addr;
    wdata          = rdata;
    done           = 1'b0;
    done_word      = '0;

    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_word.op)
            tcw_pkg::OP_PUT: begin
              if (go_scroll) begin
                col_next       = '0;
                lin_next       = POS_W'(LAST_BASE);
                cnt_next       = '0;
                walk_item_next = 1'b1;
                walk_attr_next = cur_attr;
                pend_put_next  = !is_nl;
                pend_char_next = in_word.char_code;
              end else if (is_nl) begin
                row_next = ROW_W'(row + 1'b1);
                col_next = '0;
                lin_next = lin - POS_W'(col) + POS_W'(COLS);
                done     = 1'b1;
              end else begin
                we       = 1'b1;
                waddr    = ADDR_W'(lin);
                wdata    = {cur_attr, in_word.char_code};
                lin_next = lin + 1'b1;
                done     = 1'b1;
                if (col_full) begin
                  row_next = ROW_W'(row + 1'b1);
                  col_next = COL_W'(1);
                end else begin
                  col_next = col + 1'b1;
                end
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_next       = '0;
              col_next       = '0;
              lin_next       = '0;
              cnt_next       = '0;
              walk_item_next = 1'b1;
              walk_attr_next = cur_attr;
              pend_put_next  = 1'b0;
            end
            tcw_pkg::OP_READ: begin
              if (idx_ok) begin
                re    = 1'b1;
                raddr = ADDR_W'(in_word.cell_index);
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        re            = 1'b1;
        raddr         = ADDR_W'(cnt + POS_W'(COLS));
        cp_valid_next = 1'b1;
        cp_addr_next  = ADDR_W'(cnt);
        cnt_next      = cnt + 1'b1;
      end
      tcw_pkg::ST_BLANK: begin
        if (!cp_valid) begin
          we    = 1'b1;
          waddr = ADDR_W'(cnt);
          wdata = {walk_attr, tcw_pkg::BLANK_CHAR};
          if (cnt != POS_W'(NCELLS - 1)) begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      tcw_pkg::ST_FINISH: begin
        done = 1'b1;
        if (pend_put) begin
          we       = 1'b1;
          waddr    = ADDR_W'(lin);
          wdata    = {cur_attr, pend_char};
          col_next = COL_W'(1);
          lin_next = lin + 1'b1;
        end
      end
      tcw_pkg::ST_READ: begin
        done                = 1'b1;
        done_word.read_char = rdata[7:0];
        done_word.read_attr = rdata[15:8];
      end
      tcw_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase

    done_word.cursor_pos = to_pos11(lin_next);
  end

  // output register and hold slot
  always_comb begin
    out_valid_next = out_valid;
    out_word_next  = out_word;
    hold_word_next = hold_word;
    if (done) begin
      if (out_free) begin
        out_valid_next = 1'b1;
        out_word_next  = done_word;
      end else begin
        hold_word_next = done_word;
      end
    end else if (state == tcw_pkg::ST_HOLD && !out_stall) begin
      out_valid_next = 1'b1;
      out_word_next  = hold_word;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_BLANK;
      row       <= '0;
      col       <= '0;
      lin       <= '0;
      cnt       <= '0;
      cp_valid  <= 1'b0;
      walk_item <= 1'b0;
      walk_attr <= {tcw_pkg::RESET_BG, tcw_pkg::RESET_FG};
      pend_put  <= 1'b0;
      fg        <= tcw_pkg::RESET_FG;
      bg        <= tcw_pkg::RESET_BG;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      lin       <= lin_next;
      cnt       <= cnt_next;
      cp_valid  <= cp_valid_next;
      walk_item <= walk_item_next;
      walk_attr <= walk_attr_next;
      pend_put  <= pend_put_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::REG_FOREGROUND: fg <= cfg_data;
          tcw_pkg::REG_BACKGROUND: bg <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr   <= cp_addr_next;
    pend_char <= pend_char_next;
    out_word  <= out_word_next;
    hold_word <= hold_word_next;
  end

endmodule

/* rtl/core/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_word_t out_word
);

  localparam int NCELLS = ROWS * COLS;

  logic       in_acc, out_acc;
  logic [1:0] pend;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_acc && !out_acc) begin
      pend <= pend + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend <= pend - 1'b1;
    end
  end

  a_reset_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result without accepted word");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two words outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (NCELLS < 2048) |-> 32'(out_word.cursor_pos) <= NCELLS)
    else $error("cursor past end of grid");

endmodule

bind text_console_writer tcw_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
